[rtl/dtdd_pkg.sv]
`default_nettype none

package dtdd_pkg;

  // Number of integer digits that a result run may carry.
  localparam int unsigned INT_DIGITS = 11;

  // Powers of ten, worked out at elaboration.
  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // Integer parts at or above this value are out of range.
  localparam logic [63:0] LIMIT = pow10(INT_DIGITS - 1) + 64'd1;

  // The integer part plus a rounding carry stays at or below LIMIT.
  localparam int unsigned IP_W   = $clog2(LIMIT + 64'd1);
  localparam int unsigned BCD_W  = 4 * INT_DIGITS;
  localparam int unsigned DCNT_W = $clog2(INT_DIGITS + 1);
  localparam int unsigned CCNT_W = $clog2(IP_W + 1);

  // Binary64 layout.
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned EXP_W   = 11;
  localparam int unsigned MAN_W   = 52;
  localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7FF;
  // Exponents at or above this one always give a range error.
  localparam logic [EXP_W-1:0] EXP_TOO_BIG  = 11'd1086;
  // Exponent at which the lowest significand bit weighs 2^-60.
  localparam logic [EXP_W-1:0] EXP_FRAC0    = 11'd1015;

  // Fixed point with 60 fraction bits; the aligned word spans 53 + 70 bits.
  localparam int unsigned FRAC_W = 60;
  localparam int unsigned SH_W   = 7;
  localparam int unsigned X_W    = MAN_W + 1 + 70;
  localparam int unsigned IPF_W  = X_W - FRAC_W;

  // Fraction times 100 plus one half, in fixed point.
  localparam int unsigned HUND_W = 7;
  localparam int unsigned ACC_W  = FRAC_W + HUND_W;
  localparam logic [HUND_W-1:0] HUNDRED = 7'd100;

  // Digit output width.
  localparam int unsigned DIGIT_W = 4;

  // Queue between the classifier and the sequencer.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  // One classified number waiting for conversion.
  typedef struct packed {
    logic              neg;
    logic              err;
    logic [IP_W-1:0]   ip;
    logic [FRAC_W-1:0] frac;
  } dtdd_job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic valid;
  } dtdd_qstat_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_FRAC,
    ST_CARRY,
    ST_CONV,
    ST_SKIP,
    ST_INT,
    ST_FHI,
    ST_FLO
  } dtdd_state_e;

endpackage

`default_nettype wire

[rtl/dtdd_if.sv]
`default_nettype none

// Input channel: one binary64 pattern per request.
interface dtdd_in_if;
  logic                             valid;
  logic                             ready;
  logic [dtdd_pkg::VALUE_W-1:0]     value_bits;

  modport source(output valid, output value_bits, input ready);
  modport sink(input valid, input value_bits, output ready);
endinterface

// Output channel: one decimal digit per request.
interface dtdd_out_if;
  logic                             valid;
  logic                             ready;
  logic [dtdd_pkg::DIGIT_W-1:0]     digit;
  logic                             in_fraction;
  logic                             negative;
  logic                             range_error;
  logic                             last;

  modport source(output valid, output digit, output in_fraction, output negative,
                 output range_error, output last, input ready);
  modport sink(input valid, input digit, input in_fraction, input negative,
               input range_error, input last, output ready);
endinterface

`default_nettype wire

[rtl/dtdd_front.sv]
`default_nettype none

// Classifies each binary64 request: sign, range check, and alignment of the
// significand into a fixed-point integer part and a 60-bit fraction.
module dtdd_front (
  dtdd_in_if.sink                 in_i,
  input  dtdd_pkg::dtdd_qstat_t   q_stat_i,
  output logic                    push_o,
  output dtdd_pkg::dtdd_job_t     job_o
);

  logic                            sign;
  logic [dtdd_pkg::EXP_W-1:0]      ex;
  logic [dtdd_pkg::MAN_W-1:0]      man;
  logic [dtdd_pkg::MAN_W:0]        sig;
  logic                            is_zero;
  logic                            is_nan;
  logic                            aligned;
  logic [dtdd_pkg::EXP_W-1:0]      sh_full;
  logic [dtdd_pkg::SH_W-1:0]       sh;
  logic [dtdd_pkg::X_W-1:0]        x;
  logic [dtdd_pkg::IPF_W-1:0]      ip_full;
  logic                            too_big;

  // Field split.
  assign sign    = in_i.value_bits[dtdd_pkg::VALUE_W-1];
  assign ex      = in_i.value_bits[dtdd_pkg::VALUE_W-2 -: dtdd_pkg::EXP_W];
  assign man     = in_i.value_bits[dtdd_pkg::MAN_W-1:0];
  assign sig     = {(ex != '0), man};
  assign is_zero = (ex == '0) && (man == '0);
  assign is_nan  = (ex == dtdd_pkg::EXP_ALL_ONES) && (man != '0);

  // Align the significand; values below 2^-60 per bit round to zero anyway.
  assign aligned = (ex >= dtdd_pkg::EXP_FRAC0) && (ex < dtdd_pkg::EXP_TOO_BIG);
  assign sh_full = ex - dtdd_pkg::EXP_FRAC0;
  assign sh      = sh_full[dtdd_pkg::SH_W-1:0];

  always_comb begin
    if (aligned) begin
      x = dtdd_pkg::X_W'(sig) << sh;
    end else begin
      x = '0;
    end
  end

  assign ip_full = x[dtdd_pkg::X_W-1:dtdd_pkg::FRAC_W];

  // NaN, infinity and large magnitudes give a single error result.
  assign too_big = (ex == dtdd_pkg::EXP_ALL_ONES) || (ex >= dtdd_pkg::EXP_TOO_BIG) ||
                   ({1'b0, ip_full} >= dtdd_pkg::LIMIT);

  assign job_o.neg  = sign && !is_zero && !is_nan;
  assign job_o.err  = too_big;
  assign job_o.ip   = ip_full[dtdd_pkg::IP_W-1:0];
  assign job_o.frac = x[dtdd_pkg::FRAC_W-1:0];

  // Requests are taken whenever the queue has room.
  assign in_i.ready = !q_stat_i.full;
  assign push_o     = in_i.valid && !q_stat_i.full;

endmodule

`default_nettype wire

[rtl/dtdd_queue.sv]
`default_nettype none

// Small FIFO of classified numbers between the classifier and the sequencer.
module dtdd_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  dtdd_pkg::dtdd_job_t     job_i,
  input  logic                    pop_i,
  output dtdd_pkg::dtdd_job_t     job_o,
  output dtdd_pkg::dtdd_qstat_t   stat_o
);

  dtdd_pkg::dtdd_job_t            mem_q [dtdd_pkg::Q_DEPTH];
  logic [dtdd_pkg::QPTR_W-1:0]    wr_q, wr_d;
  logic [dtdd_pkg::QPTR_W-1:0]    rd_q, rd_d;
  logic [dtdd_pkg::QCNT_W-1:0]    cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == dtdd_pkg::QCNT_W'(dtdd_pkg::Q_DEPTH));
  assign stat_o.valid = (cnt_q != '0);
  assign job_o        = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == dtdd_pkg::QPTR_W'(dtdd_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == dtdd_pkg::QPTR_W'(dtdd_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

[rtl/dtdd_back.sv]
`default_nettype none

// Sequencer: rounds the fraction to hundredths, converts the integer part to
// BCD one bit per cycle, then sends the digits through an output register.
module dtdd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dtdd_pkg::dtdd_qstat_t   q_stat_i,
  input  dtdd_pkg::dtdd_job_t     job_i,
  output logic                    pop_o,
  dtdd_out_if.source              out_o
);

  localparam logic [dtdd_pkg::ACC_W-1:0] ACC_HALF =
    dtdd_pkg::ACC_W'(1) << (dtdd_pkg::FRAC_W - 1);
  localparam logic [13:0] RECIP_10 = 14'd103;

  dtdd_pkg::dtdd_state_e             state_q, state_d;
  logic                              step_q;
  logic [dtdd_pkg::CCNT_W-1:0]       cnt_q;
  logic [dtdd_pkg::DCNT_W-1:0]       dcnt_q;
  logic [dtdd_pkg::IP_W-1:0]         ip_q;
  logic [dtdd_pkg::FRAC_W-1:0]       frac_q;
  logic [dtdd_pkg::ACC_W-1:0]        acc_q;
  logic [dtdd_pkg::HUND_W-1:0]       f_q;
  logic [dtdd_pkg::BCD_W-1:0]        bcd_q;
  logic                              neg_q;

  logic                              ov_q;
  logic [dtdd_pkg::DIGIT_W-1:0]      odigit_q;
  logic                              ofrac_q;
  logic                              oneg_q;
  logic                              oerr_q;
  logic                              olast_q;

  logic                              out_free;
  logic                              emit;
  logic [dtdd_pkg::DIGIT_W-1:0]      e_digit;
  logic                              e_frac;
  logic                              e_err;
  logic                              e_last;
  logic [dtdd_pkg::DIGIT_W-1:0]      top_digit;
  logic                              skip_zero;
  logic [dtdd_pkg::HUND_W-1:0]       fsum;
  logic [13:0]                       tens_prod;
  logic [dtdd_pkg::DIGIT_W-1:0]      f_tens;
  logic [dtdd_pkg::HUND_W-1:0]       tens_x10;
  logic [dtdd_pkg::DIGIT_W-1:0]      f_ones;

  // One double-dabble step: correct every digit, then shift the next bit in.
  function automatic logic [dtdd_pkg::BCD_W-1:0] dabble(
    input logic [dtdd_pkg::BCD_W-1:0] b,
    input logic                       bit_in
  );
    logic [dtdd_pkg::BCD_W-1:0] t;
    t = b;
    for (int i = 0; i < dtdd_pkg::INT_DIGITS; i++) begin
      if (t[4*i +: 4] >= 4'd5) begin
        t[4*i +: 4] = t[4*i +: 4] + 4'd3;
      end
    end
    return {t[dtdd_pkg::BCD_W-2:0], bit_in};
  endfunction

  assign out_free  = !ov_q || out_o.ready;
  assign top_digit = bcd_q[dtdd_pkg::BCD_W-1 -: dtdd_pkg::DIGIT_W];
  assign skip_zero = (top_digit == '0) && (dcnt_q > dtdd_pkg::DCNT_W'(1));
  assign fsum      = acc_q[dtdd_pkg::ACC_W-1:dtdd_pkg::FRAC_W];

  // Split the hundredths into two digits; exact for values below 100.
  assign tens_prod = 14'(f_q) * RECIP_10;
  assign f_tens    = tens_prod[13:10];
  assign tens_x10  = dtdd_pkg::HUND_W'({f_tens, 3'b000}) +
                     dtdd_pkg::HUND_W'({f_tens, 1'b0});
  assign f_ones    = dtdd_pkg::DIGIT_W'(f_q - tens_x10);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtdd_pkg::ST_IDLE: begin
        if (q_stat_i.valid) begin
          state_d = job_i.err ? dtdd_pkg::ST_ERR : dtdd_pkg::ST_FRAC;
        end
      end
      dtdd_pkg::ST_ERR: begin
        if (out_free) state_d = dtdd_pkg::ST_IDLE;
      end
      dtdd_pkg::ST_FRAC: begin
        if (step_q) state_d = dtdd_pkg::ST_CARRY;
      end
      dtdd_pkg::ST_CARRY: begin
        state_d = dtdd_pkg::ST_CONV;
      end
      dtdd_pkg::ST_CONV: begin
        if (cnt_q == dtdd_pkg::CCNT_W'(1)) state_d = dtdd_pkg::ST_SKIP;
      end
      dtdd_pkg::ST_SKIP: begin
        if (!skip_zero) state_d = dtdd_pkg::ST_INT;
      end
      dtdd_pkg::ST_INT: begin
        if (out_free && (dcnt_q == dtdd_pkg::DCNT_W'(1))) state_d = dtdd_pkg::ST_FHI;
      end
      dtdd_pkg::ST_FHI: begin
        if (out_free) state_d = dtdd_pkg::ST_FLO;
      end
      dtdd_pkg::ST_FLO: begin
        if (out_free) state_d = dtdd_pkg::ST_IDLE;
      end
      default: begin
        state_d = dtdd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of each state.
  always_comb begin
    pop_o   = 1'b0;
    emit    = 1'b0;
    e_digit = '0;
    e_frac  = 1'b0;
    e_err   = 1'b0;
    e_last  = 1'b0;
    unique case (state_q)
      dtdd_pkg::ST_IDLE: begin
        pop_o = q_stat_i.valid;
      end
      dtdd_pkg::ST_ERR: begin
        emit   = out_free;
        e_err  = 1'b1;
        e_last = 1'b1;
      end
      dtdd_pkg::ST_INT: begin
        emit    = out_free;
        e_digit = top_digit;
      end
      dtdd_pkg::ST_FHI: begin
        emit    = out_free;
        e_digit = f_tens;
        e_frac  = 1'b1;
      end
      dtdd_pkg::ST_FLO: begin
        emit    = out_free;
        e_digit = f_ones;
        e_frac  = 1'b1;
        e_last  = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtdd_pkg::ST_IDLE;
      step_q  <= 1'b0;
      cnt_q   <= '0;
      dcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        dtdd_pkg::ST_IDLE: begin
          step_q <= 1'b0;
        end
        dtdd_pkg::ST_FRAC: begin
          step_q <= 1'b1;
        end
        dtdd_pkg::ST_CARRY: begin
          cnt_q <= dtdd_pkg::CCNT_W'(dtdd_pkg::IP_W);
        end
        dtdd_pkg::ST_CONV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == dtdd_pkg::CCNT_W'(1)) begin
            dcnt_q <= dtdd_pkg::DCNT_W'(dtdd_pkg::INT_DIGITS);
          end
        end
        dtdd_pkg::ST_SKIP: begin
          if (skip_zero) dcnt_q <= dcnt_q - 1'b1;
        end
        dtdd_pkg::ST_INT: begin
          if (out_free) dcnt_q <= dcnt_q - 1'b1;
        end
        default: begin
          step_q <= step_q;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dtdd_pkg::ST_IDLE: begin
        if (q_stat_i.valid) begin
          neg_q  <= job_i.neg;
          ip_q   <= job_i.ip;
          frac_q <= job_i.frac;
          acc_q  <= dtdd_pkg::ACC_W'({job_i.frac, 2'b00}) + ACC_HALF;
        end
      end
      dtdd_pkg::ST_FRAC: begin
        if (step_q) begin
          acc_q <= acc_q + dtdd_pkg::ACC_W'({frac_q, 6'b000000});
        end else begin
          acc_q <= acc_q + dtdd_pkg::ACC_W'({frac_q, 5'b00000});
        end
      end
      dtdd_pkg::ST_CARRY: begin
        // A fraction that rounds to one hundred carries into the integer part.
        if (fsum == dtdd_pkg::HUNDRED) begin
          ip_q <= ip_q + dtdd_pkg::IP_W'(1);
          f_q  <= '0;
        end else begin
          f_q  <= fsum;
        end
        bcd_q <= '0;
      end
      dtdd_pkg::ST_CONV: begin
        bcd_q <= dabble(bcd_q, ip_q[dtdd_pkg::IP_W-1]);
        ip_q  <= ip_q << 1;
      end
      dtdd_pkg::ST_SKIP: begin
        if (skip_zero) bcd_q <= bcd_q << dtdd_pkg::DIGIT_W;
      end
      dtdd_pkg::ST_INT: begin
        if (out_free) bcd_q <= bcd_q << dtdd_pkg::DIGIT_W;
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
    if (emit) begin
      odigit_q <= e_digit;
      ofrac_q  <= e_frac;
      oneg_q   <= (state_q == dtdd_pkg::ST_IDLE) ? job_i.neg : neg_q;
      oerr_q   <= e_err;
      olast_q  <= e_last;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.digit       = odigit_q;
  assign out_o.in_fraction = ofrac_q;
  assign out_o.negative    = oneg_q;
  assign out_o.range_error = oerr_q;
  assign out_o.last        = olast_q;

endmodule

`default_nettype wire

[rtl/double_to_decimal_digits_unit.sv]
// Binary64 to decimal digits, two fraction digits.
//
// The input channel takes one IEEE-754 binary64 pattern per request. The
// output channel returns its magnitude as a run of digit requests: integer
// digits from the most significant (no leading zeros, a single 0 for a zero
// integer part), then two fraction digits rounded half away from zero; last
// marks the end of a run. NaN, infinity and magnitudes too large for the
// integer digits give one request with range_error and last set.
//
// A number is taken into a two-entry queue, so up to two more
// numbers are accepted while one is converted. The back sequencer rounds
// the fraction and applies the carry, runs the bit-serial binary to BCD
// conversion over the IP_W (34) bit integer part, then drops leading zeros
// and sends the rest of the 11 integer positions, then the two fraction
// digits; it takes the next number from the queue only after a run ends.
//
// Reset empties the queue and the output register. When the receiver stalls
// the held result stays put, the sequencer waits, and input requests stop
// once the queue is full.
`default_nettype none

module double_to_decimal_digits_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  dtdd_in_if.sink      in_i,
  dtdd_out_if.source   out_o
);

  dtdd_pkg::dtdd_qstat_t  q_stat;
  dtdd_pkg::dtdd_job_t    push_job;
  dtdd_pkg::dtdd_job_t    head_job;
  logic                   push;
  logic                   pop;

  dtdd_front u_front (
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (push_job)
  );

  dtdd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  dtdd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .job_i    (head_job),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  // The classifier never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("push into full queue");

  // The sequencer only takes a number that is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_stat.valid)
    else $error("pop from empty queue");

  // Every digit sent is a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.digit <= 4'd9))
    else $error("digit out of range");

  // An error result stands alone as a whole run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.range_error) |->
      (out_o.last && !out_o.in_fraction && (out_o.digit == 4'd0)))
    else $error("malformed error result");

endmodule

`default_nettype wire

[bench/tb_double_to_decimal_digits_unit.sv]
`timescale 1ns / 100ps

module tb_double_to_decimal_digits_unit;

  // Integer parts at or above this value give a range error.
  localparam logic [63:0] IP_LIMIT = 64'd10 ** (dtdd_pkg::INT_DIGITS - 1) + 64'd1;

  // Binary64 exponent landmarks.
  localparam logic [10:0] EXP_NONFINITE = 11'h7FF;
  localparam logic [10:0] EXP_OVERFLOW  = 11'd1086;
  localparam logic [10:0] EXP_UNIT_LSB  = 11'd1075;
  localparam int unsigned SUBNORM_SHIFT = 1074;
  localparam int unsigned MAX_FRAC_SHIFT = 60;
  localparam logic [63:0] BITS_1E10     = 64'h4202A05F20000000;

  localparam int unsigned NUM_DIRECTED = 25;
  localparam int unsigned NUM_RANDOM   = 235;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 100;
  // Slowest correct run: 260 numbers, each up to 13 digits with a sink stall
  // on each, plus the conversion, an input gap before each number and the long
  // hold. The limit leaves a wide margin.
  localparam int unsigned RUN_LIMIT    = 200000;

  // One digit request as seen on the output channel.
  typedef struct packed {
    logic [3:0] digit;
    logic       in_fraction;
    logic       negative;
    logic       range_error;
    logic       last;
  } digit_req_t;

  // How a directed row gets its expected digits.
  typedef enum logic {
    CHECK_PREDICTED,
    CHECK_TYPED
  } row_check_e;

  // Typed rows carry a single integer digit and the rounded hundredths.
  typedef struct packed {
    logic [63:0] value;
    row_check_e  check;
    logic        neg;
    logic        err;
    logic [3:0]  int_digit;
    logic [6:0]  hundredths;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  dtdd_in_if  in_ch();
  dtdd_out_if out_ch();

  double_to_decimal_digits_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  digit_req_t  digits_due[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned error_runs = 0;
  int unsigned cycle_cnt = 0;
  bit          no_idle = 0;
  bit          hold_wanted = 0;
  bit          hold_done = 0;

  // Extremes, non-finite values, range edges, subnormals, rounding and carry.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{64'h0000000000000000, CHECK_TYPED,     1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h8000000000000000, CHECK_TYPED,     1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h7FF0000000000000, CHECK_TYPED,     1'b0, 1'b1, 4'd0, 7'd0},
    '{64'hFFF0000000000000, CHECK_TYPED,     1'b1, 1'b1, 4'd0, 7'd0},
    '{64'h7FF8000000000000, CHECK_TYPED,     1'b0, 1'b1, 4'd0, 7'd0},
    '{64'hFFF0000000000001, CHECK_TYPED,     1'b0, 1'b1, 4'd0, 7'd0},
    '{64'h7FEFFFFFFFFFFFFF, CHECK_TYPED,     1'b0, 1'b1, 4'd0, 7'd0},
    '{64'hFFEFFFFFFFFFFFFF, CHECK_TYPED,     1'b1, 1'b1, 4'd0, 7'd0},
    '{64'h43D0000000000000, CHECK_TYPED,     1'b0, 1'b1, 4'd0, 7'd0},
    '{64'hC330000000000000, CHECK_TYPED,     1'b1, 1'b1, 4'd0, 7'd0},
    '{64'h4202A05F20080000, CHECK_TYPED,     1'b0, 1'b1, 4'd0, 7'd0},
    '{64'h4202A05F20000000, CHECK_PREDICTED, 1'b0, 1'b0, 4'd0, 7'd0},
    '{64'hC202A05F2007F800, CHECK_PREDICTED, 1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h0000000000000001, CHECK_TYPED,     1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h8000000000000001, CHECK_TYPED,     1'b1, 1'b0, 4'd0, 7'd0},
    '{64'h000FFFFFFFFFFFFF, CHECK_TYPED,     1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h0010000000000000, CHECK_TYPED,     1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h3F60000000000000, CHECK_PREDICTED, 1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h3F747AE147AE147B, CHECK_PREDICTED, 1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h3FC0000000000000, CHECK_PREDICTED, 1'b0, 1'b0, 4'd0, 7'd0},
    '{64'hBFEFF7CED916872B, CHECK_PREDICTED, 1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h4023FF7CED916873, CHECK_PREDICTED, 1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h3FF0000000000000, CHECK_TYPED,     1'b0, 1'b0, 4'd1, 7'd0},
    '{64'h405EDCCCCCCCCCCD, CHECK_PREDICTED, 1'b0, 1'b0, 4'd0, 7'd0},
    '{64'h3FE0000000000000, CHECK_TYPED,     1'b0, 1'b0, 4'd0, 7'd50}
  };

  // Works out the digit run of one binary64 pattern and queues it.
  function automatic void predict_digit_run(input logic [63:0] v);
    logic         sgn;
    logic [10:0]  ex;
    logic [51:0]  man;
    logic         neg;
    logic [63:0]  m;
    logic [63:0]  ip;
    logic [63:0]  fb;
    logic [127:0] scaled;
    int unsigned  k;
    int unsigned  f;
    logic [3:0]   int_digits[$];
    sgn = v[63];
    ex  = v[62:52];
    man = v[51:0];
    neg = sgn && !(ex == 11'd0 && man == 52'd0) && !(ex == EXP_NONFINITE && man != 52'd0);
    if (ex == EXP_NONFINITE || ex >= EXP_OVERFLOW) begin
      digits_due.push_back('{4'd0, 1'b0, neg, 1'b1, 1'b1});
      return;
    end

    // Split the significand into integer part and fraction bits.
    m  = (ex != 11'd0) ? {11'd0, 1'b1, man} : {12'd0, man};
    k  = 0;
    fb = 64'd0;
    f  = 0;
    if (ex >= EXP_UNIT_LSB) begin
      ip = m << (ex - EXP_UNIT_LSB);
    end else begin
      k = (ex != 11'd0) ? (EXP_UNIT_LSB - ex) : SUBNORM_SHIFT;
      if (k >= 64) begin
        ip = 64'd0;
        fb = m;
      end else begin
        ip = m >> k;
        fb = m & ((64'd1 << k) - 64'd1);
      end
    end
    if (ip >= IP_LIMIT) begin
      digits_due.push_back('{4'd0, 1'b0, neg, 1'b1, 1'b1});
      return;
    end

    // Hundredths, rounded half up; finer fractions always round to zero.
    if (k >= 1 && k <= MAX_FRAC_SHIFT) begin
      scaled = {64'd0, fb} * 128'd100 + (128'd1 << (k - 1));
      f = int'(scaled >> k);
    end
    if (f >= 100) begin
      f  = 0;
      ip = ip + 64'd1;
    end

    do begin
      int_digits.push_front(4'(ip % 64'd10));
      ip = ip / 64'd10;
    end while (ip != 64'd0);
    foreach (int_digits[i]) begin
      digits_due.push_back('{int_digits[i], 1'b0, neg, 1'b0, 1'b0});
    end
    digits_due.push_back('{4'(f / 10), 1'b1, neg, 1'b0, 1'b0});
    digits_due.push_back('{4'(f % 10), 1'b1, neg, 1'b0, 1'b1});
  endfunction

  // Queues the run written into a directed row.
  function automatic void push_typed_run(input directed_row_t row);
    if (row.err) begin
      digits_due.push_back('{4'd0, 1'b0, row.neg, 1'b1, 1'b1});
    end else begin
      digits_due.push_back('{row.int_digit, 1'b0, row.neg, 1'b0, 1'b0});
      digits_due.push_back('{4'(row.hundredths / 10), 1'b1, row.neg, 1'b0, 1'b0});
      digits_due.push_back('{4'(row.hundredths % 10), 1'b1, row.neg, 1'b0, 1'b1});
    end
  endfunction

  // Draws a pattern, weighted toward finite values inside the digit range.
  function automatic logic [63:0] random_pattern();
    logic [63:0] v;
    logic [63:0] ip_part;
    real         r;
    ip_part = $urandom_range(0, 1) ? 64'($urandom_range(0, 999))
                                   : {$urandom, $urandom} % IP_LIMIT;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        v[62:52] = $urandom_range(0, 1) ? EXP_NONFINITE : 11'd0;
      end
      2: begin
        // Exact eighths put the fraction on and beside rounding ties.
        r = real'(ip_part) + real'($urandom_range(0, 7)) / 8.0;
        v = $realtobits(r);
        v[63] = $urandom_range(0, 1);
      end
      3: begin
        // Fractions near one exercise the carry into the integer part.
        r = real'(ip_part) + 0.99 + real'($urandom_range(0, 10000)) * 1.0e-6;
        v = $realtobits(r);
        v[63] = $urandom_range(0, 1);
      end
      4: begin
        v = BITS_1E10 - 64'd1048576 + 64'($urandom_range(0, 2097152));
        v[63] = $urandom_range(0, 1);
      end
      default: begin
        v[62:52] = 11'($urandom_range(953, 1057));
      end
    endcase
    return v;
  endfunction

  // Presents one number and returns once it has been taken.
  task automatic offer_number(input logic [63:0] v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value_bits <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Digit sink: checks each accepted request and stalls at random.
  initial begin : digit_sink
    int unsigned rx_wait;
    int unsigned hold_left;
    digit_req_t  got;
    digit_req_t  want;
    rx_wait   = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.digit       = out_ch.digit;
        got.in_fraction = out_ch.in_fraction;
        got.negative    = out_ch.negative;
        got.range_error = out_ch.range_error;
        got.last        = out_ch.last;
        results_checked++;
        if (got.range_error) error_runs++;
        if (digits_due.size() == 0) begin
          $error("digit request with none expected: digit %0d", got.digit);
          mismatches++;
        end else begin
          want = digits_due.pop_front();
          if (got.digit !== want.digit) begin
            $error("digit: expected %0d, got %0d", want.digit, got.digit);
            mismatches++;
          end
          if (got.in_fraction !== want.in_fraction) begin
            $error("in_fraction: expected %0d, got %0d", want.in_fraction, got.in_fraction);
            mismatches++;
          end
          if (got.negative !== want.negative) begin
            $error("negative: expected %0d, got %0d", want.negative, got.negative);
            mismatches++;
          end
          if (got.range_error !== want.range_error) begin
            $error("range_error: expected %0d, got %0d", want.range_error, got.range_error);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
          end
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 5);
      end

      // A single long hold lets the block fill up and stall its input.
      if (hold_wanted && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Reset, stimulus, drain and verdict.
  initial begin
    logic [63:0] v;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.value_bits = 64'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    foreach (directed_rows[i]) begin
      offer_number(directed_rows[i].value);
      if (directed_rows[i].check == CHECK_TYPED) begin
        push_typed_run(directed_rows[i]);
      end else begin
        predict_digit_run(directed_rows[i].value);
      end
    end

    // Random numbers, with a back-to-back stretch and one long sink hold.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      no_idle = (i >= 150 && i < 190);
      if (i == 40) hold_wanted = 1;
      v = random_pattern();
      offer_number(v);
      predict_digit_run(v);
    end
    in_ch.valid <= 1'b0;

    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers (%0d from the directed table) into %0d digit requests,",
             items_sent, NUM_DIRECTED, results_checked);
    $display("including %0d out-of-range runs, with random stalls on both channels.",
             error_runs);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
